/* src/stpr_pkg.sv */
// Shared types, action codes and the 6x8 font ROM of the scrolling text page renderer.
`default_nettype none

package stpr_pkg;

	// Input action code
	typedef logic [2:0] action_t;

	localparam action_t ACT_PUT_CHAR      = 3'd0;
	localparam action_t ACT_COMMIT_SCROLL = 3'd1;
	localparam action_t ACT_COMMIT_LINE4  = 3'd2;
	localparam action_t ACT_CLEAR         = 3'd3;
	localparam action_t ACT_FETCH         = 3'd4;

	// Stored character code width and printable range
	localparam int unsigned CODE_W = 7;
	typedef logic [CODE_W-1:0] char_code_t;
	localparam char_code_t CODE_LOW  = 7'd32;
	localparam char_code_t CODE_HIGH = 7'd126;

	// Glyph geometry, page index of line four
	localparam int unsigned GLYPH_WIDTH = 6;
	localparam int unsigned LINE_FOUR   = 3;
	localparam int unsigned GLYPH_COUNT = 95;

	typedef logic [7:0] pixel_col_t;

	// Six column bytes per glyph, leftmost column in the top byte
	localparam logic [47:0] GLYPH_ROM [GLYPH_COUNT] = '{
		48'h000000000000, 48'h00005F000000, 48'h000700070000, 48'h147F147F1400,
		48'h242A7F2A1200, 48'h231308646200, 48'h364955225000, 48'h000503000000,
		48'h001C22410000, 48'h0041221C0000, 48'h082A1C2A0800, 48'h08083E080800,
		48'h005030000000, 48'h080808080800, 48'h006060000000, 48'h201008040200,
		48'h3E5149453E00, 48'h00427F400000, 48'h426151494600, 48'h2141454B3100,
		48'h1814127F1000, 48'h274545453900, 48'h3C4A49493000, 48'h017109050300,
		48'h364949493600, 48'h064949291E00, 48'h003636000000, 48'h005636000000,
		48'h081422410000, 48'h141414141400, 48'h004122140800, 48'h020151090600,
		48'h324979413E00, 48'h7E1111117E00, 48'h7F4949493600, 48'h3E4141412200,
		48'h7F4141221C00, 48'h7F4949494100, 48'h7F0909090100, 48'h3E4149497A00,
		48'h7F0808087F00, 48'h00417F410000, 48'h2040413F0100, 48'h7F0814224100,
		48'h7F4040404000, 48'h7F020C027F00, 48'h7F0408107F00, 48'h3E4141413E00,
		48'h7F0909090600, 48'h3E4151215E00, 48'h7F0919294600, 48'h464949493100,
		48'h01017F010100, 48'h3F4040403F00, 48'h1F2040201F00, 48'h3F4038403F00,
		48'h631408146300, 48'h070870080700, 48'h615149454300, 48'h007F41410000,
		48'h020408102000, 48'h0041417F0000, 48'h040201020400, 48'h404040404000,
		48'h000102040000, 48'h205454547800, 48'h7F4844443800, 48'h384444442000,
		48'h384444487F00, 48'h385454541800, 48'h087E09010200, 48'h0C5252523E00,
		48'h7F0804047800, 48'h00447D400000, 48'h2040443D0000, 48'h7F1028440000,
		48'h00417F400000, 48'h7C0418047800, 48'h7C0804047800, 48'h384444443800,
		48'h7C1414140800, 48'h081414187C00, 48'h7C0804040800, 48'h485454542000,
		48'h043F44402000, 48'h3C4040207C00, 48'h1C2040201C00, 48'h3C4030403C00,
		48'h442810284400, 48'h0C5050503C00, 48'h4464544C4400, 48'h000836410000,
		48'h00007F000000, 48'h004136080000, 48'h08082A1C0800
	};

	// Column byte of a glyph; codes outside the printable range draw as space
	function automatic pixel_col_t glyph_column(input char_code_t code, input logic [2:0] sub);
		logic [47:0] bits;
		char_code_t  rom_idx;
		pixel_col_t  col;
		rom_idx = code - CODE_LOW;
		if (code < CODE_LOW || code > CODE_HIGH) begin
			bits = GLYPH_ROM[0];
		end else begin
			bits = GLYPH_ROM[rom_idx];
		end
		case (sub)
			3'd0:    col = bits[47:40];
			3'd1:    col = bits[39:32];
			3'd2:    col = bits[31:24];
			3'd3:    col = bits[23:16];
			3'd4:    col = bits[15:8];
			3'd5:    col = bits[7:0];
			default: col = 8'h00;
		endcase
		return col;
	endfunction

endpackage

`default_nettype wire

/* src/stpr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module stpr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 8
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read; data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/scrolling_text_page_renderer_core.sv */
// Top level of the scrolling text page renderer: staging line, line store and fetch pipeline.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one action per transfer: put a
//   character into the staging line, commit it as a scrolled bottom line or as
//   line four, clear all lines, or fetch one pixel column byte.
//   Output channel (out_valid / out_stall) carries one transfer per fetch only:
//   pixel_byte with the page and column echoed. Other actions give no output.
//   Throughput: one item per cycle in steady state while out_stall is low. A fetch
//   result passes the input register, the line store read and the output register.
//   The line store is a RAM with one row per text line, so a commit writes a whole
//   line at once and a fetch reads one row.
//   When out_stall is high the output register holds; the stage behind it
//   still takes one more fetch and non-fetch actions keep flowing, after which
//   in_stall rises until the output drains.
//   Reset (arst_n low) empties the staging line, zeroes all line lengths and
//   the top line pointer and drops items in flight. The line store itself is
//   not cleared; only characters below a line's length are ever shown.
`default_nettype none

module scrolling_text_page_renderer_core #(
	parameter int unsigned PANEL_WIDTH = 128,
	parameter int unsigned TEXT_ROWS   = 8,
	parameter int unsigned LINE_CHARS  = 21
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire stpr_pkg::action_t action,
	input  wire logic [7:0]       character,
	input  wire logic [2:0]       page,
	input  wire logic [6:0]       column,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [7:0]            pixel_byte,
	output logic [2:0]            out_page,
	output logic [6:0]            out_column
);

	import stpr_pkg::*;

	localparam int unsigned ROW_W      = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1;
	localparam int unsigned SUM_W      = ROW_W + 4;
	localparam int unsigned LEN_W      = $clog2(LINE_CHARS + 1);
	localparam int unsigned CIDX_W     = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
	localparam int unsigned CMP_W      = (LEN_W > 5) ? LEN_W : 5;
	localparam int unsigned ROW_BITS   = LINE_CHARS * CODE_W;
	localparam bit          HAS_LINE_4 = (LINE_FOUR < TEXT_ROWS);

	typedef logic [ROW_W-1:0] slot_t;
	typedef logic [LEN_W-1:0] len_t;

	// Reduce top pointer plus page offset into the slot range
	function automatic slot_t wrap_slot(input logic [SUM_W-1:0] sum);
		logic [SUM_W-1:0] red;
		red = (sum >= SUM_W'(TEXT_ROWS)) ? (sum - SUM_W'(TEXT_ROWS)) : sum;
		return red[ROW_W-1:0];
	endfunction

	// Handshake and stage control
	logic s1_valid_q, s2_valid_q, out_valid_q;
	logic out_ready, s2_ready, s1_leave, in_xfer;
	logic is_fetch_s1, fetch_go;

	// Stage 1 payload
	action_t    act_s1;
	logic [7:0] char_s1;
	logic [2:0] page_s1;
	logic [6:0] column_s1;

	// Text state
	slot_t      top_q;
	len_t       staging_len_q;
	char_code_t staging_q [LINE_CHARS];
	len_t       line_len_q [TEXT_ROWS];
	logic [ROW_BITS-1:0] staging_row;

	// Decoded action
	logic do_put, do_scroll, do_line4, do_clear;
	logic commit_we;
	slot_t commit_slot, line4_slot;
	char_code_t put_code;

	// Fetch address math
	slot_t       fetch_slot;
	logic        page_ok, col_ok, idx_ok, fetch_ok;
	logic [12:0] col_prod;
	logic [4:0]  col_idx;
	logic [7:0]  idx_times6;
	logic [7:0]  col_rem;
	logic [9:0]  glyph_end;
	len_t        fetch_len;

	// Stage 2 payload
	logic              ok_s2;
	logic [CIDX_W-1:0] idx_s2;
	logic [2:0]        sub_s2;
	logic [2:0]        page_s2;
	logic [6:0]        column_s2;
	logic [ROW_BITS-1:0] row_s2;
	char_code_t        row_chars [LINE_CHARS];

	// Output register
	logic [7:0] pixel_q;
	logic [2:0] page_q;
	logic [6:0] column_q;

	// Stall chain: output register, row read stage, input register
	assign out_ready   = !out_valid_q || !out_stall;
	assign s2_ready    = !s2_valid_q || out_ready;
	assign is_fetch_s1 = (act_s1 == ACT_FETCH);
	assign s1_leave    = s1_valid_q && (!is_fetch_s1 || s2_ready);
	assign in_stall    = s1_valid_q && !s1_leave;
	assign in_xfer     = in_valid && !in_stall;
	assign fetch_go    = s1_leave && is_fetch_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= in_xfer || (s1_valid_q && !s1_leave);
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			act_s1    <= action;
			char_s1   <= character;
			page_s1   <= page;
			column_s1 <= column;
		end
	end

	// Decode the action as it leaves the input register
	always_comb begin
		do_put    = 1'b0;
		do_scroll = 1'b0;
		do_line4  = 1'b0;
		do_clear  = 1'b0;
		unique case (act_s1)
			ACT_PUT_CHAR:      do_put    = s1_leave;
			ACT_COMMIT_SCROLL: do_scroll = s1_leave;
			ACT_COMMIT_LINE4:  do_line4  = s1_leave;
			ACT_CLEAR:         do_clear  = s1_leave;
			default:           ;
		endcase
	end

	// Replace unprintable codes with space
	assign put_code = (char_s1 < 8'(CODE_LOW) || char_s1 > 8'(CODE_HIGH))
		? CODE_LOW : char_s1[CODE_W-1:0];

	assign line4_slot  = wrap_slot(SUM_W'(top_q) + SUM_W'(LINE_FOUR));
	assign commit_slot = do_scroll ? top_q : line4_slot;
	assign commit_we   = do_scroll || (do_line4 && HAS_LINE_4);

	// Staging line
	always_ff @(posedge clk) begin
		if (do_put && (staging_len_q < len_t'(LINE_CHARS))) begin
			staging_q[staging_len_q[CIDX_W-1:0]] <= put_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			staging_len_q <= '0;
		end else if (do_scroll || do_line4) begin
			staging_len_q <= '0;
		end else if (do_put && (staging_len_q < len_t'(LINE_CHARS))) begin
			staging_len_q <= staging_len_q + len_t'(1);
		end
	end

	// Top line pointer: advance on scroll, drop to zero on clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
		end else if (do_clear) begin
			top_q <= '0;
		end else if (do_scroll) begin
			top_q <= (top_q == slot_t'(TEXT_ROWS - 1)) ? '0 : top_q + slot_t'(1);
		end
	end

	// Line lengths, one per stored line
	for (genvar r = 0; r < TEXT_ROWS; r++) begin : g_len
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				line_len_q[r] <= '0;
			end else if (do_clear) begin
				line_len_q[r] <= '0;
			end else if (commit_we && (commit_slot == slot_t'(r))) begin
				line_len_q[r] <= staging_len_q;
			end
		end
	end

	// Pack the staging line for a whole-row write
	for (genvar c = 0; c < LINE_CHARS; c++) begin : g_pack
		assign staging_row[c*CODE_W +: CODE_W] = staging_q[c];
		assign row_chars[c] = row_s2[c*CODE_W +: CODE_W];
	end

	// Fetch address: character index is column / 6 as (column * 43) >> 8, exact below 128
	assign col_prod   = 13'(column_s1) * 13'd43;
	assign col_idx    = col_prod[12:8];
	assign idx_times6 = {1'b0, col_idx, 2'b00} + {2'b00, col_idx, 1'b0};
	assign col_rem    = {1'b0, column_s1} - idx_times6;
	assign glyph_end  = 10'(idx_times6) + 10'(GLYPH_WIDTH);

	assign page_ok    = ({2'b00, page_s1} < 5'(TEXT_ROWS));
	assign fetch_slot = page_ok ? wrap_slot(SUM_W'(top_q) + SUM_W'(page_s1)) : '0;
	assign fetch_len  = line_len_q[fetch_slot];
	assign col_ok     = ({3'b000, column_s1} < 10'(PANEL_WIDTH)) &&
		(glyph_end <= 10'(PANEL_WIDTH));
	assign idx_ok     = (CMP_W'(col_idx) < CMP_W'(fetch_len)) &&
		(CMP_W'(col_idx) < CMP_W'(LINE_CHARS));
	assign fetch_ok   = page_ok && col_ok && idx_ok;

	// Line store: one row per text line
	stpr_ram #(
		.WIDTH(ROW_BITS),
		.DEPTH(TEXT_ROWS)
	) u_line_store (
		.clk  (clk),
		.we   (commit_we),
		.waddr(commit_slot),
		.wdata(staging_row),
		.re   (fetch_go),
		.raddr(fetch_slot),
		.rdata(row_s2)
	);

	// Row read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else begin
			s2_valid_q <= fetch_go || (s2_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (fetch_go) begin
			ok_s2     <= fetch_ok;
			idx_s2    <= fetch_ok ? CIDX_W'(col_idx) : '0;
			sub_s2    <= col_rem[2:0];
			page_s2   <= page_s1;
			column_s2 <= column_s1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= s2_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && s2_valid_q) begin
			pixel_q  <= ok_s2 ? glyph_column(row_chars[idx_s2], sub_s2) : 8'h00;
			page_q   <= page_s2;
			column_q <= column_s2;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_byte = pixel_q;
	assign out_page   = page_q;
	assign out_column = column_q;

endmodule

`default_nettype wire

/* src/stpr_checker.sv */
// Port-level checker for the scrolling text page renderer, bound to the top level.
`default_nettype none

module stpr_checker #(
	parameter int unsigned PANEL_WIDTH = 128,
	parameter int unsigned TEXT_ROWS   = 8
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] pixel_byte,
	input wire logic [2:0] out_page,
	input wire logic [6:0] out_column
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_byte) &&
		$stable(out_page) && $stable(out_column))
		else $error("stalled output transfer changed");

	// Font columns never light the bottom pixel
	a_bit7_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !pixel_byte[7])
		else $error("pixel byte has bit 7 set");

	// Columns beyond the panel are dark
	a_col_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ({3'b000, out_column} >= 10'(PANEL_WIDTH)) |-> pixel_byte == 8'h00)
		else $error("column beyond panel width is lit");

	// Pages beyond the text rows are dark
	a_page_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ({2'b00, out_page} >= 5'(TEXT_ROWS)) |-> pixel_byte == 8'h00)
		else $error("page beyond text rows is lit");

endmodule

bind scrolling_text_page_renderer_core stpr_checker #(
	.PANEL_WIDTH(PANEL_WIDTH),
	.TEXT_ROWS  (TEXT_ROWS)
) u_stpr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.pixel_byte(pixel_byte),
	.out_page  (out_page),
	.out_column(out_column)
);

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the scrolling text page renderer core.
`timescale 1ns / 1ps

module tb;
	import stpr_pkg::*;

	localparam int unsigned PANEL = 128;
	localparam int unsigned ROWS = 8;
	localparam int unsigned CHARS = 21;
	localparam int unsigned GLYPH_W = 6;
	localparam int unsigned LATENCY = 2;
	localparam int unsigned RESET_CYCLES = 12;
	localparam int unsigned ITEM_TARGET = 1625;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned MAX_REPORTS = 10;

	// Actions the block ignores
	localparam action_t ACT_SPARE_FIRST = 3'd5;
	localparam action_t ACT_SPARE_LAST = 3'd7;

	// Font columns per printable code, leftmost column in the top byte
	localparam logic [47:0] FONT_COLS [95] = '{
		48'h000000000000, 48'h00005F000000, 48'h000700070000, 48'h147F147F1400,
		48'h242A7F2A1200, 48'h231308646200, 48'h364955225000, 48'h000503000000,
		48'h001C22410000, 48'h0041221C0000, 48'h082A1C2A0800, 48'h08083E080800,
		48'h005030000000, 48'h080808080800, 48'h006060000000, 48'h201008040200,
		48'h3E5149453E00, 48'h00427F400000, 48'h426151494600, 48'h2141454B3100,
		48'h1814127F1000, 48'h274545453900, 48'h3C4A49493000, 48'h017109050300,
		48'h364949493600, 48'h064949291E00, 48'h003636000000, 48'h005636000000,
		48'h081422410000, 48'h141414141400, 48'h004122140800, 48'h020151090600,
		48'h324979413E00, 48'h7E1111117E00, 48'h7F4949493600, 48'h3E4141412200,
		48'h7F4141221C00, 48'h7F4949494100, 48'h7F0909090100, 48'h3E4149497A00,
		48'h7F0808087F00, 48'h00417F410000, 48'h2040413F0100, 48'h7F0814224100,
		48'h7F4040404000, 48'h7F020C027F00, 48'h7F0408107F00, 48'h3E4141413E00,
		48'h7F0909090600, 48'h3E4151215E00, 48'h7F0919294600, 48'h464949493100,
		48'h01017F010100, 48'h3F4040403F00, 48'h1F2040201F00, 48'h3F4038403F00,
		48'h631408146300, 48'h070870080700, 48'h615149454300, 48'h007F41410000,
		48'h020408102000, 48'h0041417F0000, 48'h040201020400, 48'h404040404000,
		48'h000102040000, 48'h205454547800, 48'h7F4844443800, 48'h384444442000,
		48'h384444487F00, 48'h385454541800, 48'h087E09010200, 48'h0C5252523E00,
		48'h7F0804047800, 48'h00447D400000, 48'h2040443D0000, 48'h7F1028440000,
		48'h00417F400000, 48'h7C0418047800, 48'h7C0804047800, 48'h384444443800,
		48'h7C1414140800, 48'h081414187C00, 48'h7C0804040800, 48'h485454542000,
		48'h043F44402000, 48'h3C4040207C00, 48'h1C2040201C00, 48'h3C4030403C00,
		48'h442810284400, 48'h0C5050503C00, 48'h4464544C4400, 48'h000836410000,
		48'h00007F000000, 48'h004136080000, 48'h08082A1C0800
	};

	typedef struct packed {
		logic [7:0] pixel;
		logic [2:0] pg;
		logic [6:0] col;
	} column_result_t;

	// Mirror of the text panel: predicts each fetched column byte
	class text_panel_model;
		char_code_t line_chars [ROWS][CHARS];
		int unsigned line_len [ROWS];
		int unsigned top_slot;
		char_code_t stage_chars [CHARS];
		int unsigned stage_len;
		column_result_t pending_columns [$];
		int unsigned errors;

		function new();
			foreach (line_len[i]) line_len[i] = 0;
			top_slot = 0;
			stage_len = 0;
			errors = 0;
		endfunction

		function void flag(string what, column_result_t want, column_result_t got);
			errors++;
			if (errors <= MAX_REPORTS) begin
				$display("%s: expected px=%02h page=%0d col=%0d, got px=%02h page=%0d col=%0d",
					what, want.pixel, want.pg, want.col, got.pixel, got.pg, got.col);
			end
		endfunction

		function void load_slot(int unsigned slot);
			for (int unsigned i = 0; i < stage_len; i++) line_chars[slot][i] = stage_chars[i];
			line_len[slot] = stage_len;
		endfunction

		function column_result_t render_column(logic [2:0] pg, logic [6:0] col);
			column_result_t res;
			int unsigned slot, idx, sub;
			logic [47:0] bits;
			res.pixel = '0;
			res.pg = pg;
			res.col = col;
			slot = (top_slot + pg) % ROWS;
			idx = col / GLYPH_W;
			sub = col % GLYPH_W;
			if (pg < ROWS && col < PANEL && idx < line_len[slot] && idx < CHARS
					&& idx * GLYPH_W + GLYPH_W <= PANEL) begin
				bits = FONT_COLS[line_chars[slot][idx] - CODE_LOW];
				res.pixel = bits[47 - 8 * sub -: 8];
			end
			return res;
		endfunction

		// Apply one accepted input transfer
		function void note_input(action_t act, logic [7:0] ch, logic [2:0] pg, logic [6:0] col);
			case (act)
				ACT_PUT_CHAR: begin
					if (stage_len < CHARS) begin
						if (ch < CODE_LOW || ch > CODE_HIGH) stage_chars[stage_len] = CODE_LOW;
						else stage_chars[stage_len] = ch[6:0];
						stage_len++;
					end
				end
				ACT_COMMIT_SCROLL: begin
					load_slot(top_slot);
					top_slot = (top_slot + 1) % ROWS;
					stage_len = 0;
				end
				ACT_COMMIT_LINE4: begin
					if (LINE_FOUR < ROWS) load_slot((top_slot + LINE_FOUR) % ROWS);
					stage_len = 0;
				end
				ACT_CLEAR: begin
					foreach (line_len[i]) line_len[i] = 0;
					top_slot = 0;
				end
				ACT_FETCH: pending_columns.push_back(render_column(pg, col));
				default: ;
			endcase
		endfunction

		// Compare one output transfer with the oldest prediction
		function void check_result(logic [7:0] px, logic [2:0] pg, logic [6:0] col);
			column_result_t got, want;
			got.pixel = px;
			got.pg = pg;
			got.col = col;
			if (pending_columns.size() == 0) begin
				flag("unexpected column result", '0, got);
			end else begin
				want = pending_columns.pop_front();
				if (got !== want) flag("column result mismatch", want, got);
			end
		endfunction

		function int unsigned pending();
			return pending_columns.size();
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	action_t action = ACT_PUT_CHAR;
	logic [7:0] character = '0;
	logic [2:0] page = '0;
	logic [6:0] column = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] pixel_byte;
	logic [2:0] out_page;
	logic [6:0] out_column;

	text_panel_model panel = new();
	int unsigned items_sent = 0;
	int unsigned cycle_count = 0;
	bit sender_quiet = 0;
	bit hold_req = 0;
	bit hold_active = 0;

	scrolling_text_page_renderer_core #(
		.PANEL_WIDTH(PANEL),
		.TEXT_ROWS(ROWS),
		.LINE_CHARS(CHARS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.character(character),
		.page(page),
		.column(column),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_byte(pixel_byte),
		.out_page(out_page),
		.out_column(out_column)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Gap lengths: mostly none or short, a few long
	function automatic int unsigned pick_gap(bit no_idle);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [7:0] pick_char();
		if ($urandom_range(0, 9) < 8) return 8'($urandom_range(CODE_LOW, CODE_HIGH));
		return 8'($urandom_range(0, 255));
	endfunction

	// Columns: anywhere, inside the written text, or near the right edge
	function automatic logic [6:0] pick_column(int unsigned n);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45 || n == 0) return 7'($urandom_range(0, PANEL - 1));
		if (r < 80) return 7'($urandom_range(0, ((n > CHARS) ? CHARS : n) * GLYPH_W - 1));
		return 7'($urandom_range(PANEL - 14, PANEL - 1));
	endfunction

	// Check output transfers, then record input transfers, at each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) panel.check_result(pixel_byte, out_page, out_column);
			if (in_valid && !in_stall) panel.note_input(action, character, page, column);
		end
	end

	// Offer one item and hold it until the transfer
	task automatic send_item(action_t act, logic [7:0] ch, logic [2:0] pg, logic [6:0] col);
		int unsigned gap;
		gap = pick_gap(sender_quiet);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		character <= ch;
		page <= pg;
		column <= col;
		do @(posedge clk); while (in_stall);
		if (act <= ACT_FETCH) items_sent++;
	endtask

	task automatic send_put(logic [7:0] ch);
		send_item(ACT_PUT_CHAR, ch, 3'($urandom), 7'($urandom));
	endtask

	task automatic send_fetch(logic [2:0] pg, logic [6:0] col);
		send_item(ACT_FETCH, 8'($urandom), pg, col);
	endtask

	task automatic send_cmd(action_t act);
		send_item(act, 8'($urandom), 3'($urandom), 7'($urandom));
	endtask

	// Stop offering until every predicted column has arrived
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (panel.pending() != 0);
	endtask

	// Fill the staging line, commit it, then read some columns back
	task automatic build_line();
		int unsigned n, k;
		if ($urandom_range(0, 99) < 85) n = $urandom_range(0, CHARS);
		else n = $urandom_range(CHARS + 1, CHARS + 5);
		for (int unsigned i = 0; i < n; i++) send_put(pick_char());
		send_cmd(($urandom_range(0, 9) < 7) ? ACT_COMMIT_SCROLL : ACT_COMMIT_LINE4);
		k = $urandom_range(1, 8);
		for (int unsigned i = 0; i < k; i++) send_fetch(3'($urandom), pick_column(n));
	endtask

	// Receiver: random stalls, plus one long hold on request
	initial begin
		int unsigned n;
		int unsigned hold_count;
		repeat (RESET_CYCLES) @(posedge clk);
		forever begin
			if (hold_req) begin
				hold_active = 1;
				out_stall <= 1'b1;
				hold_count = 0;
				while (hold_count < HOLD_CYCLES) begin
					@(posedge clk);
					hold_count++;
				end
				hold_req = 0;
				hold_active = 0;
			end else begin
				n = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 6);
				out_stall <= 1'b0;
				repeat (n) @(posedge clk);
				n = pick_gap(0);
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
		end
	end

	// Timeout
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb NOT OK");
		$finish;
	end

	initial begin
		int unsigned r, k;
		bit hold_done;
		hold_done = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: code extremes, every action, spare actions, clear, empty commits
		send_put(8'd0);
		send_put(8'd31);
		send_put(8'd32);
		send_put(8'd126);
		send_put(8'd127);
		send_put(8'd255);
		send_put(8'd65);
		send_cmd(ACT_COMMIT_SCROLL);
		send_fetch(3'd7, 7'd0);
		send_fetch(3'd7, 7'd18);
		send_fetch(3'd7, 7'd41);
		send_fetch(3'd7, 7'd42);
		send_fetch(3'd0, 7'd127);
		send_put(8'd48);
		send_cmd(ACT_COMMIT_LINE4);
		send_fetch(3'd3, 7'd2);
		for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++) send_cmd(action_t'(a));
		send_fetch(3'd3, 7'd0);
		send_cmd(ACT_CLEAR);
		send_fetch(3'd3, 7'd2);
		send_fetch(3'd7, 7'd1);
		send_cmd(ACT_COMMIT_LINE4);
		send_cmd(ACT_COMMIT_SCROLL);
		drain();

		// Random: mostly well-formed lines and fetches, some noise
		while (items_sent < ITEM_TARGET) begin
			sender_quiet = ($urandom_range(0, 9) < 2);
			r = $urandom_range(0, 99);
			if (r < 50) begin
				build_line();
			end else if (r < 75) begin
				k = $urandom_range(8, 40);
				for (int unsigned i = 0; i < k; i++) send_fetch(3'($urandom), pick_column(CHARS));
			end else if (r < 80) begin
				send_cmd(ACT_CLEAR);
			end else if (r < 85) begin
				send_cmd(action_t'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)));
			end else if (r < 95) begin
				k = $urandom_range(1, 4);
				for (int unsigned i = 0; i < k; i++)
					send_item(action_t'($urandom), 8'($urandom), 3'($urandom), 7'($urandom));
			end else begin
				drain();
			end

			// Long receiver hold while fetches keep coming, so the input backs up
			if (!hold_done && items_sent > ITEM_TARGET / 2) begin
				hold_done = 1;
				hold_req = 1;
				in_valid <= 1'b0;
				do @(posedge clk); while (!hold_active);
				sender_quiet = 1;
				for (int unsigned i = 0; i < 60; i++) send_fetch(3'($urandom), pick_column(CHARS));
				drain();
			end
		end

		// Wait out the pipeline, then report
		drain();
		repeat (LATENCY + 8) @(posedge clk);
		if (panel.pending() != 0) panel.errors++;
		if (panel.errors == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

/* sim.f */
src/stpr_pkg.sv
src/stpr_ram.sv
src/scrolling_text_page_renderer_core.sv
src/stpr_checker.sv
verif/tb.sv
